>>> sv/voqgms_pkg.sv
// Shared constants, types and lane control bundle for the VOQ scheduler.
`timescale 1ns / 1ps

package voqgms_pkg;

  // Switch size and counter width
  localparam int PORTS       = 8;
  localparam int COUNT_WIDTH = 10;
  localparam int IDX_W       = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int SUM_W       = COUNT_WIDTH + 1;

  // Fixed field widths of the slot and result items
  localparam int DEST_W         = 3;
  localparam int ARRIVAL_INPUTS = 8;
  localparam int MASK_W         = 8;
  localparam int DEST_BUS_W     = DEST_W * ARRIVAL_INPUTS;
  localparam int BURST_W        = 3;
  localparam int GRANT_W        = 64;
  localparam int MATCH_W        = 4;
  localparam int MATCH_CNT_W    = $clog2(PORTS + 1);

  localparam logic [BURST_W-1:0] BURST_RESET = 3'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;

  localparam count_t COUNT_MAX = '1;

  // Control from the sequencer to every row lane
  typedef struct packed {
    logic               capture;
    logic               update;
    logic [PORTS-1:0]   col_alive;
    logic [BURST_W-1:0] burst;
  } lane_ctl_t;

endpackage

>>> sv/voqgms_lane.sv
// Row lane: holds one input's queue counters, finds its row maximum, applies service and arrivals.
`timescale 1ns / 1ps

module voqgms_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  voqgms_pkg::lane_ctl_t             ctl,
  input  logic                              row_alive,
  input  logic [voqgms_pkg::PORTS-1:0]      grant_row,
  input  logic                              arrive,
  input  logic [voqgms_pkg::DEST_W-1:0]     dest,
  output voqgms_pkg::count_t                best_val,
  output voqgms_pkg::idx_t                  best_col,
  output logic                              drop
);

  voqgms_pkg::count_t cnt      [voqgms_pkg::PORTS];
  voqgms_pkg::count_t cnt_next [voqgms_pkg::PORTS];
  voqgms_pkg::count_t scan_val;
  voqgms_pkg::idx_t   scan_col;
  logic [voqgms_pkg::PORTS-1:0] drop_vec;

  // Find the largest live counter of this row, first column wins a tie
  always_comb begin
    scan_val = '0;
    scan_col = '0;
    for (int j = 0; j < voqgms_pkg::PORTS; j++) begin
      if (row_alive && ctl.col_alive[j] && (cnt[j] > scan_val)) begin
        scan_val = cnt[j];
        scan_col = voqgms_pkg::IDX_W'(j);
      end
    end
  end

  // Decrement served queues, then add the burst unless it overflows
  always_comb begin
    voqgms_pkg::count_t            base;
    logic [voqgms_pkg::SUM_W-1:0]  sum;
    logic                          hit;
    logic                          over;
    for (int j = 0; j < voqgms_pkg::PORTS; j++) begin
      base = cnt[j] - voqgms_pkg::COUNT_WIDTH'(grant_row[j] && (cnt[j] != '0));
      hit  = arrive && (32'(dest) == j);
      sum  = {1'b0, base} + voqgms_pkg::SUM_W'(ctl.burst);
      over = sum > {1'b0, voqgms_pkg::COUNT_MAX};
      cnt_next[j] = (hit && !over) ? sum[voqgms_pkg::COUNT_WIDTH-1:0] : base;
      drop_vec[j] = hit && over;
    end
  end

  assign drop = |drop_vec;

  // Hold counters, load the next values on an update; clear at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < voqgms_pkg::PORTS; j++) begin
        cnt[j] <= '0;
      end
    end else if (ctl.update) begin
      cnt <= cnt_next;
    end
  end

  // Register the row result for the merge stage
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      best_val <= scan_val;
      best_col <= scan_col;
    end
  end

endmodule

>>> sv/voqgms_merge.sv
// Merge stage: picks the largest nonzero lane result, first row wins a tie.
`timescale 1ns / 1ps

module voqgms_merge (
  input  voqgms_pkg::count_t lane_val [voqgms_pkg::PORTS],
  input  voqgms_pkg::idx_t   lane_col [voqgms_pkg::PORTS],
  output logic               hit,
  output voqgms_pkg::idx_t   best_row,
  output voqgms_pkg::idx_t   best_col
);

  voqgms_pkg::count_t best_val;

  // Strict greater-than keeps the earliest row and skips zero counts
  always_comb begin
    best_val = '0;
    best_row = '0;
    best_col = '0;
    for (int i = 0; i < voqgms_pkg::PORTS; i++) begin
      if (lane_val[i] > best_val) begin
        best_val = lane_val[i];
        best_row = voqgms_pkg::IDX_W'(i);
        best_col = lane_col[i];
      end
    end
  end

  assign hit = best_val != '0;

endmodule

>>> sv/voq_greedy_max_weight_scheduler_unit.sv
// Top level: slot sequencer, row lanes, merge stage and result register.
`timescale 1ns / 1ps
//
// Crossbar scheduler for an 8x8 switch with one packet counter per
// input/output pair. Each slot item enters on in_valid/in_ready. When
// serve_enable is set, greedy matching runs in rounds: in each round the
// row lanes register their row maximum, then the merge stage picks the
// global maximum, grants it and retires its row and column. Matching ends
// at the first round with no nonzero live counter. The apply state then
// decrements the granted counters, adds arrival bursts and loads the
// result register. With serving off the item goes straight to the apply
// state. A new item is taken only once the block is back in idle after
// loading the result.
// The result waits in an output register while out_ready is low; the block
// still takes the next item and runs its matching, and holds in the update
// cycle until the register frees. burst_size is written via cfg_wr_en and
// cfg_wr_data. Reset clears all counters, sets burst_size to 3 and drops
// any pending result.

module voq_greedy_max_weight_scheduler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [voqgms_pkg::BURST_W-1:0]      cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                serve_enable,
  input  logic [voqgms_pkg::MASK_W-1:0]       arrive_mask,
  input  logic [voqgms_pkg::DEST_BUS_W-1:0]   arrive_dest,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [voqgms_pkg::GRANT_W-1:0]      grant_matrix,
  output logic [voqgms_pkg::MATCH_W-1:0]      matched_count,
  output logic [voqgms_pkg::MASK_W-1:0]       drop_mask
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_APPLY
  } state_t;

  state_t state;

  logic [voqgms_pkg::BURST_W-1:0]     burst;
  logic [voqgms_pkg::MASK_W-1:0]      slot_mask;
  logic [voqgms_pkg::DEST_BUS_W-1:0]  slot_dest;
  logic [voqgms_pkg::PORTS-1:0]       row_alive;
  logic [voqgms_pkg::PORTS-1:0]       col_alive;
  logic [voqgms_pkg::PORTS-1:0]       grant [voqgms_pkg::PORTS];
  logic [voqgms_pkg::MATCH_CNT_W-1:0] match_cnt;

  voqgms_pkg::lane_ctl_t ctl;
  voqgms_pkg::count_t    lane_val [voqgms_pkg::PORTS];
  voqgms_pkg::idx_t      lane_col [voqgms_pkg::PORTS];
  logic [voqgms_pkg::PORTS-1:0] lane_drop;

  logic             pick_hit;
  voqgms_pkg::idx_t pick_row;
  voqgms_pkg::idx_t pick_col;

  logic in_fire;
  logic apply_go;
  logic [voqgms_pkg::GRANT_W-1:0] grant_flat;
  logic [voqgms_pkg::MASK_W-1:0]  drop_flat;

  assign in_ready = state == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign apply_go = (state == S_APPLY) && (!out_valid || out_ready);

  // Drive the lane control bundle
  always_comb begin
    ctl.capture   = state == S_SCAN;
    ctl.update    = apply_go;
    ctl.col_alive = col_alive;
    ctl.burst     = burst;
  end

  // Row lanes, one per input
  for (genvar i = 0; i < voqgms_pkg::PORTS; i++) begin : g_lane
    logic                          lane_arrive;
    logic [voqgms_pkg::DEST_W-1:0] lane_dest;

    if (i < voqgms_pkg::ARRIVAL_INPUTS) begin : g_arr
      assign lane_arrive = slot_mask[i];
      assign lane_dest   = slot_dest[voqgms_pkg::DEST_W*i +: voqgms_pkg::DEST_W];
    end else begin : g_noarr
      assign lane_arrive = 1'b0;
      assign lane_dest   = '0;
    end

    voqgms_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .row_alive (row_alive[i]),
      .grant_row (grant[i]),
      .arrive    (lane_arrive),
      .dest      (lane_dest),
      .best_val  (lane_val[i]),
      .best_col  (lane_col[i]),
      .drop      (lane_drop[i])
    );
  end

  voqgms_merge u_merge (
    .lane_val (lane_val),
    .lane_col (lane_col),
    .hit      (pick_hit),
    .best_row (pick_row),
    .best_col (pick_col)
  );

  // Flatten grants and drops into the result layout
  always_comb begin
    grant_flat = '0;
    drop_flat  = '0;
    for (int i = 0; i < voqgms_pkg::PORTS; i++) begin
      for (int j = 0; j < voqgms_pkg::PORTS; j++) begin
        if (i * voqgms_pkg::PORTS + j < voqgms_pkg::GRANT_W) begin
          grant_flat[i * voqgms_pkg::PORTS + j] = grant[i][j];
        end
      end
      if (i < voqgms_pkg::MASK_W) begin
        drop_flat[i] = lane_drop[i];
      end
    end
  end

  // Burst size register
  always_ff @(posedge clk) begin
    if (rst) begin
      burst <= voqgms_pkg::BURST_RESET;
    end else if (cfg_wr_en) begin
      burst <= cfg_wr_data;
    end
  end

  // Sequence the slot: accept, scan and pick rounds, apply, load result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      match_cnt <= '0;
      row_alive <= '0;
      col_alive <= '0;
      for (int i = 0; i < voqgms_pkg::PORTS; i++) begin
        grant[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !apply_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            slot_mask <= arrive_mask;
            slot_dest <= arrive_dest;
            row_alive <= '1;
            col_alive <= '1;
            match_cnt <= '0;
            for (int i = 0; i < voqgms_pkg::PORTS; i++) begin
              grant[i] <= '0;
            end
            state <= serve_enable ? S_SCAN : S_APPLY;
          end
        end
        S_SCAN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (pick_hit) begin
            grant[pick_row][pick_col] <= 1'b1;
            row_alive[pick_row]       <= 1'b0;
            col_alive[pick_col]       <= 1'b0;
            match_cnt                 <= match_cnt + 1'b1;
            state                     <= S_SCAN;
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            out_valid     <= 1'b1;
            grant_matrix  <= grant_flat;
            matched_count <= voqgms_pkg::MATCH_W'(match_cnt);
            drop_mask     <= drop_flat;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A picked pair must come from a live row and a live column
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pick_hit) |-> (row_alive[pick_row] && col_alive[pick_col]))
    else $error("picked pair lies in a retired row or column");

  // Matching never grants more pairs than there are ports
  assert property (@(posedge clk) disable iff (rst)
    32'(match_cnt) <= voqgms_pkg::PORTS)
    else $error("match count exceeds port count");

  // An update cycle always presents a result next
  assert property (@(posedge clk) disable iff (rst)
    apply_go |=> out_valid)
    else $error("result not presented after update");

  // Every granted pair removes its row from later rounds
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pick_hit) |=> !row_alive[$past(pick_row)])
    else $error("granted row still live");

endmodule
